// File: design/bmp_pkg.sv
// Shared types, codes and the color conversion for the bitmap stream decoder.
`timescale 1ns / 1ps

package bmp_pkg;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_PIXELS  = 2'd1,
      PH_STOPPED = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PIXEL    = 2'd0,
      KIND_BAD_SIG  = 2'd1,
      KIND_READ_ERR = 2'd2
   } kind_type;

   localparam logic [7:0] SIG_FIRST    = 8'h42;  // 'B'
   localparam logic [7:0] SIG_SECOND   = 8'h4D;  // 'M'
   localparam logic [7:0] POS_SIG_LAST = 8'd1;
   localparam logic [7:0] POS_OFFSET   = 8'd10;
   localparam logic [7:0] POS_WIDTH    = 8'd18;
   localparam logic [7:0] POS_HEIGHT   = 8'd22;
   localparam logic [7:0] MIN_START    = 8'd11;
   localparam logic [7:0] POS_MAX      = 8'd255;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       read_failed;
      logic       first_byte;
   } item_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] pixel_index;
      logic [7:0]  column;
      logic [7:0]  row;
      logic [15:0] color;
      logic        last_pixel;
   } result_type;

   // RGB555 to RGB565, green low bit forced to zero
   function automatic logic [15:0] to_rgb565(input logic [15:0] word);
      return {word[14:10], word[9:5], 1'b0, word[4:0]};
   endfunction

endpackage

// File: design/bmp_parse.sv
// Header parser, pixel sequencer and result builder for one byte per cycle in which step is high.
`timescale 1ns / 1ps

module bmp_parse
   import bmp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  item_type   item,
   output logic       result_valid,
   output result_type result
);

   phase_type  phase_ff,  phase_in;
   logic [7:0] pos_ff,    pos_in;
   logic [7:0] offset_ff, offset_in;
   logic [7:0] width_ff,  width_in;
   logic [7:0] height_ff, height_in;
   logic [7:0] col_ff,    col_in;
   logic [7:0] row_ff,    row_in;
   logic [8:0] hold_ff,   hold_in;

   // state as seen by this byte, after a restart if it carries one
   phase_type  eff_phase;
   logic [7:0] eff_pos, eff_offset, eff_width, eff_height, eff_col, eff_row;
   logic [8:0] eff_hold;

   logic [8:0]  next_pos;
   logic [7:0]  start_pos;
   logic [15:0] word;
   logic        last_col;
   logic        last;

   always_comb begin
      if (item.first_byte) begin
         eff_phase  = PH_HEADER;
         eff_pos    = '0;
         eff_offset = '0;
         eff_width  = '0;
         eff_height = '0;
         eff_col    = '0;
         eff_row    = '0;
         eff_hold   = '0;
      end else begin
         eff_phase  = phase_ff;
         eff_pos    = pos_ff;
         eff_offset = offset_ff;
         eff_width  = width_ff;
         eff_height = height_ff;
         eff_col    = col_ff;
         eff_row    = row_ff;
         eff_hold   = hold_ff;
      end
   end

   always_comb begin
      phase_in     = eff_phase;
      pos_in       = eff_pos;
      offset_in    = eff_offset;
      width_in     = eff_width;
      height_in    = eff_height;
      col_in       = eff_col;
      row_in       = eff_row;
      hold_in      = eff_hold;
      result_valid = 1'b0;
      result       = '0;
      next_pos     = {1'b0, eff_pos} + 9'd1;
      start_pos    = MIN_START;
      word         = {item.data_byte, eff_hold[7:0]};
      last_col     = ({1'b0, eff_col} + 9'd1) >= {1'b0, eff_width};
      last         = last_col && (eff_row == '0);

      case (eff_phase)
         PH_HEADER: begin
            if (item.read_failed) begin
               phase_in     = PH_STOPPED;
               result_valid = 1'b1;
               result.kind  = KIND_READ_ERR;
            end else if (eff_pos == POS_SIG_LAST &&
                         (eff_hold != '0 || item.data_byte != SIG_SECOND)) begin
               phase_in     = PH_STOPPED;
               result_valid = 1'b1;
               result.kind  = KIND_BAD_SIG;
            end else begin
               if (eff_pos == '0 && item.data_byte != SIG_FIRST) begin
                  hold_in = 9'd1;
               end
               if (eff_pos == POS_SIG_LAST) begin
                  hold_in = '0;
               end
               if (eff_pos == POS_OFFSET) begin
                  offset_in = item.data_byte;
               end
               if (eff_pos == POS_WIDTH) begin
                  width_in = item.data_byte;
               end
               if (eff_pos == POS_HEIGHT) begin
                  height_in = item.data_byte;
               end
               if (offset_in > MIN_START) begin
                  start_pos = offset_in;
               end
               if (eff_pos >= POS_OFFSET && next_pos >= {1'b0, start_pos}) begin
                  hold_in = '0;
                  if (width_in == '0 || height_in == '0) begin
                     phase_in = PH_STOPPED;
                  end else begin
                     phase_in = PH_PIXELS;
                     col_in   = '0;
                     row_in   = height_in - 8'd1;
                  end
               end
               pos_in = next_pos[8] ? POS_MAX : next_pos[7:0];
            end
         end
         PH_PIXELS: begin
            if (item.read_failed) begin
               phase_in     = PH_STOPPED;
               result_valid = 1'b1;
               result.kind  = KIND_READ_ERR;
            end else if (!eff_hold[8]) begin
               hold_in = {1'b1, item.data_byte};
            end else begin
               hold_in            = '0;
               result_valid       = 1'b1;
               result.kind        = KIND_PIXEL;
               result.pixel_index = 16'(eff_row * eff_width) + {8'd0, eff_col};
               result.column      = eff_col;
               result.row         = eff_row;
               result.color       = to_rgb565(word);
               result.last_pixel  = last;
               if (last) begin
                  phase_in = PH_STOPPED;
               end else if (last_col) begin
                  col_in = '0;
                  row_in = eff_row - 8'd1;
               end else begin
                  col_in = eff_col + 8'd1;
               end
            end
         end
         default: begin
            // stopped: drop bytes until a restart
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         pos_ff    <= '0;
         offset_ff <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
         hold_ff   <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         offset_ff <= offset_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         hold_ff   <= hold_in;
      end
   end

   property p_error_stops;
      @(posedge clock) disable iff (reset)
         (step && result_valid && result.kind != KIND_PIXEL) |=> phase_ff == PH_STOPPED;
   endproperty
   a_error_stops: assert property (p_error_stops)
      else $error("error result did not stop the parser");

   property p_pixel_clears_hold;
      @(posedge clock) disable iff (reset)
         (step && result_valid && result.kind == KIND_PIXEL) |=> !hold_ff[8];
   endproperty
   a_pixel_clears_hold: assert property (p_pixel_clears_hold)
      else $error("held byte survived a pixel result");

   property p_pixels_nonempty;
      @(posedge clock) disable iff (reset)
         (phase_ff == PH_PIXELS) |-> (width_ff != '0 && height_ff != '0);
   endproperty
   a_pixels_nonempty: assert property (p_pixels_nonempty)
      else $error("pixel phase entered with empty image");

endmodule

// File: design/bmp_rgb555_stream_decoder.sv
// Top level: input register, parser and result register of the bitmap stream decoder.
// Bytes go from the input register through the parser to the result register driving rsp_.
// One byte per cycle when not stalled; the row times width multiply sits in the result stage.
// Bytes that give no result pass the result stage even while rsp_stall holds a result.
// Reset clears all parser state; the stream is then parsed from byte 0 without a restart.
`timescale 1ns / 1ps

module bmp_rgb555_stream_decoder
   import bmp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_read_failed,
   input  logic        req_first_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_pixel_index,
   output logic [7:0]  rsp_column,
   output logic [7:0]  rsp_row,
   output logic [15:0] rsp_color,
   output logic        rsp_last_pixel
);

   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff,  in_item_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff,       out_in;

   logic       has_result;
   result_type result;
   logic       out_free;
   logic       advance;

   bmp_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .item         (in_item_ff),
      .result_valid (has_result),
      .result       (result)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!has_result || out_free);
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
         in_item_in  = '{data_byte: req_data_byte, read_failed: req_read_failed,
                         first_byte: req_first_byte};
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance && has_result) begin
         out_valid_in = 1'b1;
         out_in       = result;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_item_ff <= in_item_in;
      out_ff     <= out_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_kind        = out_ff.kind;
   assign rsp_pixel_index = out_ff.pixel_index;
   assign rsp_column      = out_ff.column;
   assign rsp_row         = out_ff.row;
   assign rsp_color       = out_ff.color;
   assign rsp_last_pixel  = out_ff.last_pixel;

   // a byte with a result blocked by a full output must stay in the input register
   property p_blocked_item_kept;
      @(posedge clock) disable iff (reset)
         (in_valid_ff && has_result && !out_free) |=> in_valid_ff;
   endproperty
   a_blocked_item_kept: assert property (p_blocked_item_kept)
      else $error("input byte lost while output was full");

   property p_error_fields_zero;
      @(posedge clock) disable iff (reset)
         (rsp_valid && rsp_kind != KIND_PIXEL) |->
            (rsp_pixel_index == '0 && rsp_column == '0 && rsp_row == '0 &&
             rsp_color == '0 && !rsp_last_pixel);
   endproperty
   a_error_fields_zero: assert property (p_error_fields_zero)
      else $error("error transfer carries nonzero pixel fields");

   property p_last_on_bottom_row;
      @(posedge clock) disable iff (reset)
         (rsp_valid && rsp_last_pixel) |-> (rsp_row == '0 && rsp_kind == KIND_PIXEL);
   endproperty
   a_last_on_bottom_row: assert property (p_last_on_bottom_row)
      else $error("last pixel flagged off row zero");

endmodule
